@@ hw/rtl/xxh_pkg.sv @@
// ----------------------------------------------------------------------------
// xxh_pkg: shared types and constants
// Primes, queue depth, the front-to-back command record, the back-end state codes and a rotate.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    localparam int unsigned QDEPTH = 2;

    // command kinds passed from the front end to the back end
    typedef enum logic [1:0] {
        CMD_STRIPE = 2'd0,
        CMD_FINAL  = 2'd1,
        CMD_FINAL_STRIPE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [1:0]  npend;
        logic [3:0]  nbytes;
        logic [63:0] total;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STRIPE_A,
        ST_STRIPE_B,
        ST_MERGE_SUM,
        ST_MERGE_A,
        ST_MERGE_B,
        ST_MERGE_C,
        ST_TAIL_A,
        ST_TAIL_B,
        ST_TAIL_C,
        ST_AVAL_A,
        ST_AVAL_B,
        ST_DONE
    } t_state;

    function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
        rotl = (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

endpackage

@@ hw/rtl/xxh_if.sv @@
// ----------------------------------------------------------------------------
// xxh_if: stream channels
// Valid/ready channels for message words, digests and seed writes.
// ----------------------------------------------------------------------------
interface xxh_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

interface xxh_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;
    modport source (output valid, output digest, input ready);
    modport sink (input valid, input digest, output ready);
endinterface

interface xxh_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed;
    modport source (output valid, output seed, input ready);
    modport sink (input valid, input seed, output ready);
endinterface

@@ hw/rtl/xxhash64_stream_hasher_top.sv @@
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_top: streaming XXH64 hasher
// Intake front end, command queue and multi-cycle hashing engine.
// ----------------------------------------------------------------------------
// channel   dir  payload                       transaction
// in_word   in   data_word, byte_count, last   valid & ready
// out_dig   out  digest                        valid & ready
// cfg       in   seed                          valid & ready
//
// every 64-bit multiply is built up in partial products on one 32x32 multiplier
// a stripe takes the command, then does 8 multiplies;
// the final word adds the merge sum, the merge (length >= 32),
// each pending or 8-byte tail word, each 4-byte or single-byte piece,
// leaving the tail, the avalanche and the digest hand-off, which can wait for ready
// the two-entry queue lets intake run ahead; synchronous active-low reset
// seed writes are taken only when the engine is idle and the queue empty
module xxhash64_stream_hasher_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xxh_word_if.sink     in_word,
    xxh_digest_if.source out_dig,
    xxh_cfg_if.sink      cfg
);
    logic          f_valid, f_ready, q_valid, q_ready, cfg_wr;
    xxh_pkg::t_cmd f_cmd, q_cmd;

    assign cfg.ready = !q_valid && q_ready;
    assign cfg_wr = cfg.valid && cfg.ready;

    xxh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_word), .i_cfg_wr(cfg_wr),
        .o_cmd_valid(f_valid), .o_cmd(f_cmd), .i_cmd_ready(f_ready)
    );

    xxh_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_cmd(f_cmd),
        .o_rd_valid(q_valid), .i_rd_ready(q_ready), .o_rd_cmd(q_cmd)
    );

    xxh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr(cfg_wr), .i_cfg_seed(cfg.seed),
        .i_cmd_valid(q_valid), .o_cmd_ready(q_ready), .i_cmd(q_cmd),
        .out_ch(out_dig)
    );
endmodule

@@ hw/rtl/xxh_front.sv @@
// ----------------------------------------------------------------------------
// xxh_front: word intake
// Buffers words into stripes, tracks the byte total and issues commands.
// ----------------------------------------------------------------------------
module xxh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xxh_word_if.sink      in_ch,
    input  logic          i_cfg_wr,
    output logic          o_cmd_valid,
    output xxh_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    logic [63:0] r_pend [3];
    logic [1:0]  r_cnt, n_cnt;
    logic [63:0] r_total, n_total;
    logic [3:0]  nb;
    logic        emit, acc;

    assign in_ch.ready = i_cmd_ready && !i_cfg_wr;
    assign acc = in_ch.valid && in_ch.ready;
    assign nb = !in_ch.last ? 4'd8 : (in_ch.byte_count > 4'd8 ? 4'd8 : in_ch.byte_count);

    always_comb begin
        o_cmd.w0 = r_pend[0];
        o_cmd.w1 = r_pend[1];
        o_cmd.w2 = r_pend[2];
        o_cmd.w3 = in_ch.data_word;
        o_cmd.npend = r_cnt;
        o_cmd.nbytes = nb;
        n_total = r_total + {60'd0, nb};
        o_cmd.total = n_total;
        emit = 1'b0;
        o_cmd.kind = xxh_pkg::CMD_STRIPE;
        n_cnt = r_cnt;
        if (in_ch.last) begin
            emit = 1'b1;
            n_cnt = 2'd0;
            if (nb == 4'd8 && r_cnt == 2'd3) begin
                o_cmd.kind = xxh_pkg::CMD_FINAL_STRIPE;
                o_cmd.npend = 2'd0;
                o_cmd.nbytes = 4'd0;
            end else begin
                o_cmd.kind = xxh_pkg::CMD_FINAL;
            end
        end else if (r_cnt == 2'd3) begin
            emit = 1'b1;
            n_cnt = 2'd0;
        end else begin
            n_cnt = r_cnt + 2'd1;
        end
    end

    assign o_cmd_valid = in_ch.valid && !i_cfg_wr && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_cnt   <= 2'd0;
            r_total <= 64'd0;
        end else if (acc) begin
            r_cnt   <= n_cnt;
            r_total <= in_ch.last ? 64'd0 : n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !in_ch.last && r_cnt != 2'd3) begin
            r_pend[r_cnt] <= in_ch.data_word;
        end
    end
endmodule

@@ hw/rtl/xxh_queue.sv @@
// ----------------------------------------------------------------------------
// xxh_queue: command fifo
// Short queue decoupling intake from the hashing engine.
// ----------------------------------------------------------------------------
module xxh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  xxh_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output xxh_pkg::t_cmd o_rd_cmd
);
    xxh_pkg::t_cmd r_mem [xxh_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_wr_ready = r_cnt != 2'(xxh_pkg::QDEPTH);
    assign o_rd_valid = r_cnt != 2'd0;
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;
    assign o_rd_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_cmd;
    end
endmodule

@@ hw/rtl/xxh_back.sv @@
// ----------------------------------------------------------------------------
// xxh_back: hashing engine
// Lane rounds, merge, tail folding and avalanche on a shared multiplier.
// ----------------------------------------------------------------------------
module xxh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr,
    input  logic [63:0]   i_cfg_seed,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  xxh_pkg::t_cmd i_cmd,
    xxh_digest_if.source  out_ch
);
    xxh_pkg::t_state r_st, n_st;
    logic [63:0] r_seed;
    logic [63:0] r_lane [4];
    logic [63:0] r_w [4];
    logic [63:0] r_h, r_t;
    logic [1:0]  r_i;
    logic [1:0]  r_np;
    logic [3:0]  r_nb;
    logic [63:0] r_total;
    logic        r_final;
    logic        r_oval;
    logic [63:0] r_dig;
    logic [63:0] tl;
    logic [1:0]  tidx;
    logic        ld;
    logic [63:0] m_a, m_b;
    logic        m_use;
    logic [1:0]  r_ph;
    logic [63:0] r_acc;
    logic [31:0] mx, my;
    logic [63:0] prod, mres;
    logic        step;
    logic        dig_load;

    assign out_ch.valid = r_oval;
    assign out_ch.digest = r_dig;

    // operands of the multiply needed in the current state
    always_comb begin
        m_use = 1'b1;
        m_a   = 64'd0;
        m_b   = xxh_pkg::P1;
        case (r_st)
            xxh_pkg::ST_STRIPE_A: begin
                m_a = r_w[r_i];
                m_b = xxh_pkg::P2;
            end
            xxh_pkg::ST_STRIPE_B: m_a = xxh_pkg::rotl(r_lane[r_i] + r_t, 6'd31);
            xxh_pkg::ST_MERGE_A: begin
                m_a = r_lane[r_i];
                m_b = xxh_pkg::P2;
            end
            xxh_pkg::ST_MERGE_B: m_a = xxh_pkg::rotl(r_t, 6'd31);
            xxh_pkg::ST_MERGE_C: m_a = r_h ^ r_t;
            xxh_pkg::ST_TAIL_A: begin
                if (r_np != 2'd0) begin
                    m_a = tl;
                    m_b = xxh_pkg::P2;
                end else if (r_nb == 4'd8) begin
                    m_a = r_w[3];
                    m_b = xxh_pkg::P2;
                end else if (r_nb >= 4'd4) begin
                    m_a = {32'd0, r_w[3][31:0]};
                end else if (r_nb != 4'd0) begin
                    m_a = {56'd0, r_w[3][7:0]};
                    m_b = xxh_pkg::P5;
                end else begin
                    m_use = 1'b0;
                end
            end
            xxh_pkg::ST_TAIL_B: begin
                if (r_np != 2'd0 || r_nb == 4'd8) begin
                    m_a = xxh_pkg::rotl(r_t, 6'd31);
                end else if (r_nb >= 4'd4) begin
                    m_a = xxh_pkg::rotl(r_h ^ r_t, 6'd23);
                    m_b = xxh_pkg::P2;
                end else begin
                    m_a = xxh_pkg::rotl(r_h ^ r_t, 6'd11);
                end
            end
            xxh_pkg::ST_TAIL_C: begin
                if (r_np != 2'd0 || r_nb == 4'd8) begin
                    m_a = xxh_pkg::rotl(r_h ^ r_t, 6'd27);
                end else begin
                    m_use = 1'b0;
                end
            end
            xxh_pkg::ST_AVAL_A: begin
                m_a = r_h ^ {33'd0, r_h[63:33]};
                m_b = xxh_pkg::P2;
            end
            xxh_pkg::ST_AVAL_B: begin
                m_a = r_t ^ {29'd0, r_t[63:29]};
                m_b = xxh_pkg::P3;
            end
            default: m_use = 1'b0;
        endcase
    end

    // low 64 bits of a 64x64 product from three 32x32 partial products:
    // lo*lo, then lo*hi and hi*lo shifted up by 32
    assign mx   = (r_ph == 2'd2) ? m_a[63:32] : m_a[31:0];
    assign my   = (r_ph == 2'd1) ? m_b[63:32] : m_b[31:0];
    assign prod = {32'd0, mx} * {32'd0, my};
    assign mres = r_acc + {prod[31:0], 32'd0};
    assign step = !m_use || (r_ph == 2'd2);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            xxh_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_st = (i_cmd.kind == xxh_pkg::CMD_FINAL) ? xxh_pkg::ST_MERGE_SUM
                                                              : xxh_pkg::ST_STRIPE_A;
                end
            end
            xxh_pkg::ST_STRIPE_A: n_st = xxh_pkg::ST_STRIPE_B;
            xxh_pkg::ST_STRIPE_B: begin
                if (r_i == 2'd3) begin
                    n_st = r_final ? xxh_pkg::ST_MERGE_SUM : xxh_pkg::ST_IDLE;
                end else begin
                    n_st = xxh_pkg::ST_STRIPE_A;
                end
            end
            xxh_pkg::ST_MERGE_SUM: begin
                n_st = (r_total >= 64'd32) ? xxh_pkg::ST_MERGE_A : xxh_pkg::ST_TAIL_A;
            end
            xxh_pkg::ST_MERGE_A: n_st = xxh_pkg::ST_MERGE_B;
            xxh_pkg::ST_MERGE_B: n_st = xxh_pkg::ST_MERGE_C;
            xxh_pkg::ST_MERGE_C: n_st = (r_i == 2'd3) ? xxh_pkg::ST_TAIL_A : xxh_pkg::ST_MERGE_A;
            xxh_pkg::ST_TAIL_A: begin
                if (r_np == 2'd0 && r_nb == 4'd0) begin
                    n_st = xxh_pkg::ST_AVAL_A;
                end else begin
                    n_st = xxh_pkg::ST_TAIL_B;
                end
            end
            xxh_pkg::ST_TAIL_B: n_st = xxh_pkg::ST_TAIL_C;
            xxh_pkg::ST_TAIL_C: n_st = xxh_pkg::ST_TAIL_A;
            xxh_pkg::ST_AVAL_A: n_st = xxh_pkg::ST_AVAL_B;
            xxh_pkg::ST_AVAL_B: n_st = xxh_pkg::ST_DONE;
            xxh_pkg::ST_DONE: n_st = (!r_oval || out_ch.ready) ? xxh_pkg::ST_IDLE
                                                               : xxh_pkg::ST_DONE;
            default: n_st = xxh_pkg::ST_IDLE;
        endcase
        // hold while a multiply is still in its partial products
        if (!step) begin
            n_st = r_st;
        end
    end

    // outputs
    always_comb begin
        o_cmd_ready = (r_st == xxh_pkg::ST_IDLE);
    end

    assign ld = o_cmd_ready && i_cmd_valid;
    assign dig_load = (r_st == xxh_pkg::ST_DONE) && (!r_oval || out_ch.ready);
    // index of next pending tail word
    assign tidx = r_i;
    assign tl = r_w[tidx];

    always_ff @(posedge i_clk) begin
        if (r_ph == 2'd0) begin
            r_acc <= prod;
        end else begin
            r_acc <= mres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (dig_load) begin
            r_oval <= 1'b1;
        end else if (out_ch.ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= xxh_pkg::ST_IDLE;
            r_ph   <= 2'd0;
            r_seed <= 64'd0;
            r_lane[0] <= xxh_pkg::P1 + xxh_pkg::P2;
            r_lane[1] <= xxh_pkg::P2;
            r_lane[2] <= 64'd0;
            r_lane[3] <= 64'd0 - xxh_pkg::P1;
        end else if (i_cfg_wr) begin
            r_seed <= i_cfg_seed;
            r_lane[0] <= i_cfg_seed + xxh_pkg::P1 + xxh_pkg::P2;
            r_lane[1] <= i_cfg_seed + xxh_pkg::P2;
            r_lane[2] <= i_cfg_seed;
            r_lane[3] <= i_cfg_seed - xxh_pkg::P1;
        end else begin
            r_st <= n_st;
            r_ph <= step ? 2'd0 : r_ph + 2'd1;
            case (r_st)
                xxh_pkg::ST_IDLE: begin
                    if (ld) begin
                        r_w[0] <= i_cmd.w0;
                        r_w[1] <= i_cmd.w1;
                        r_w[2] <= i_cmd.w2;
                        r_w[3] <= i_cmd.w3;
                        r_np <= i_cmd.npend;
                        r_nb <= i_cmd.nbytes;
                        r_total <= i_cmd.total;
                        r_final <= i_cmd.kind != xxh_pkg::CMD_STRIPE;
                        r_i <= 2'd0;
                    end
                end
                xxh_pkg::ST_STRIPE_A: begin
                    if (step) r_t <= mres;
                end
                xxh_pkg::ST_STRIPE_B: begin
                    if (step) begin
                        r_lane[r_i] <= mres;
                        r_i <= r_i + 2'd1;
                    end
                end
                xxh_pkg::ST_MERGE_SUM: begin
                    r_i <= 2'd0;
                    if (r_total >= 64'd32) begin
                        r_h <= xxh_pkg::rotl(r_lane[0], 6'd1) + xxh_pkg::rotl(r_lane[1], 6'd7)
                             + xxh_pkg::rotl(r_lane[2], 6'd12)
                             + xxh_pkg::rotl(r_lane[3], 6'd18);
                    end else begin
                        r_h <= r_seed + xxh_pkg::P5 + r_total;
                    end
                end
                xxh_pkg::ST_MERGE_A: begin
                    if (step) r_t <= mres;
                end
                xxh_pkg::ST_MERGE_B: begin
                    if (step) r_t <= mres;
                end
                xxh_pkg::ST_MERGE_C: begin
                    if (step) begin
                        r_h <= mres + xxh_pkg::P4 + ((r_i == 2'd3) ? r_total : 64'd0);
                        r_i <= (r_i == 2'd3) ? 2'd0 : r_i + 2'd1;
                    end
                end
                xxh_pkg::ST_TAIL_A: begin
                    // first multiply of the next tail piece
                    if (step) r_t <= mres;
                end
                xxh_pkg::ST_TAIL_B: begin
                    if (step) r_t <= mres;
                end
                xxh_pkg::ST_TAIL_C: begin
                    if (step) begin
                        if (r_np != 2'd0) begin
                            r_h <= mres + xxh_pkg::P4;
                            r_np <= r_np - 2'd1;
                            r_i <= r_i + 2'd1;
                        end else if (r_nb == 4'd8) begin
                            r_h <= mres + xxh_pkg::P4;
                            r_nb <= 4'd0;
                        end else if (r_nb >= 4'd4) begin
                            r_h <= r_t + xxh_pkg::P3;
                            r_nb <= r_nb - 4'd4;
                            r_w[3] <= {32'd0, r_w[3][63:32]};
                        end else begin
                            r_h <= r_t;
                            r_nb <= r_nb - 4'd1;
                            r_w[3] <= {8'd0, r_w[3][63:8]};
                        end
                    end
                end
                xxh_pkg::ST_AVAL_A: begin
                    if (step) r_t <= mres;
                end
                xxh_pkg::ST_AVAL_B: begin
                    if (step) r_h <= mres;
                end
                xxh_pkg::ST_DONE: begin
                    if (dig_load) begin
                        r_dig  <= r_h ^ {32'd0, r_h[63:32]};
                        r_lane[0] <= r_seed + xxh_pkg::P1 + xxh_pkg::P2;
                        r_lane[1] <= r_seed + xxh_pkg::P2;
                        r_lane[2] <= r_seed;
                        r_lane[3] <= r_seed - xxh_pkg::P1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
